### rtl/rcsp_pkg.sv
`timescale 1ns / 1ps

package rcsp_pkg;

    // Pool geometry.
    localparam int SLOTS    = 128;
    localparam int IDX_W    = $clog2(SLOTS);
    localparam int LINK_W   = IDX_W + 1;
    localparam int REFS_W   = 16;
    localparam int DATA_W   = 64;
    localparam int USED_W   = 8;
    localparam int MAX_REFS = 65520;

    // Stream item widths, padded to whole bytes.
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 104;

    // Command codes.
    typedef enum logic [2:0] {
        CMD_ALLOC    = 3'd0,
        CMD_ALLOC_AT = 3'd1,
        CMD_SHARE    = 3'd2,
        CMD_UNSHARE  = 3'd3,
        CMD_READ     = 3'd4
    } cmd_t;

    // Status codes.
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_RANGE    = 3'd2,
        ST_NOT_USED = 3'd3,
        ST_OVERFLOW = 3'd4
    } status_t;

    // Per-slot bookkeeping held in one memory word.
    typedef struct packed {
        logic              alloc;
        logic [REFS_W-1:0] refs;
        logic [LINK_W-1:0] link;
    } meta_t;

    // One result item.
    typedef struct packed {
        status_t           status;
        logic [IDX_W-1:0]  slot;
        logic [DATA_W-1:0] data;
        logic [REFS_W-1:0] refs;
        logic              in_use;
        logic [USED_W-1:0] used;
    } result_t;

endpackage

### rtl/refcounted_slot_pool.sv
`timescale 1ns / 1ps

// Reference-counted slot pool: 128 slots of 64-bit data, each with a 16-bit
// reference count, free slots kept on a linked free stack. One command item
// in, one result item out. Slot bookkeeping (allocated flag, count, free link)
// lives in one synchronous memory and the data words in a second one; a command
// that reaches a slot is a read and a decision, with a write-back where the
// slot or its data changes (accept/read, then decide/write). alloc_at on a free
// slot that is not at the head of the free stack walks the stack one link per
// cycle through the bookkeeping memory's read port, then claims the slot if it
// finds it. No clearing pass is needed after reset: a per-slot written flag
// makes an untouched slot read as free with its reset link. A finished result
// waits in the output register while the next item is taken.
module refcounted_slot_pool
    import rcsp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // cmd[2:0], slot_index[10:3], data_value[74:11], zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // status[2:0], result_slot[9:3], read_data[73:10], ref_count[89:74],
    // slot_in_use[90], used_count[98:91], zero pad
    output logic [M_TDATA_W-1:0] m_tdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_WALK,
        S_CLAIM,
        S_RESP
    } state_t;

    localparam int RES_W = $bits(result_t);

    // Input fields.
    logic [2:0]        in_cmd;
    logic [7:0]        in_index;
    logic [DATA_W-1:0] in_value;

    assign in_cmd   = s_tdata[2:0];
    assign in_index = s_tdata[10:3];
    assign in_value = s_tdata[74:11];

    // Control and payload registers.
    state_t            state_reg, state_next;
    logic [2:0]        cmd_reg, cmd_next;
    logic [IDX_W-1:0]  target_reg, target_next;
    logic [DATA_W-1:0] value_reg, value_next;
    logic [LINK_W-1:0] head_reg, head_next;
    logic [USED_W-1:0] used_reg, used_next;
    logic [IDX_W-1:0]  prev_reg, prev_next;
    logic [LINK_W-1:0] steps_reg, steps_next;
    logic [LINK_W-1:0] idx_link_reg, idx_link_next;
    result_t           res_reg, res_next;
    logic              m_tvalid_reg;
    result_t           out_reg;

    // Bookkeeping memory with per-slot written flags.
    meta_t             meta_mem [SLOTS];
    logic [SLOTS-1:0]  written_reg;
    logic              meta_re, meta_we;
    logic [IDX_W-1:0]  meta_raddr, meta_waddr;
    meta_t             meta_wdata;
    meta_t             meta_q;
    logic              rd_written_reg;
    logic [IDX_W-1:0]  rd_addr_reg;
    meta_t             meta_rd;

    // Data memory.
    logic [DATA_W-1:0] data_mem [SLOTS];
    logic              data_we;
    logic [IDX_W-1:0]  data_waddr;
    logic [DATA_W-1:0] data_q;

    logic              out_free;
    logic              accept;
    logic [REFS_W:0]   refs_inc;

    // Memory ports.
    always_ff @(posedge aclk) begin
        if (meta_we) begin
            meta_mem[meta_waddr] <= meta_wdata;
        end
        if (meta_re) begin
            meta_q         <= meta_mem[meta_raddr];
            rd_written_reg <= written_reg[meta_raddr];
            rd_addr_reg    <= meta_raddr;
            data_q         <= data_mem[meta_raddr];
        end
        if (data_we) begin
            data_mem[data_waddr] <= value_reg;
        end
    end

    // Written flags: an untouched slot is free and links to the next slot.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
        end else if (meta_we) begin
            written_reg[meta_waddr] <= 1'b1;
        end
    end

    always_comb begin
        if (rd_written_reg) begin
            meta_rd = meta_q;
        end else begin
            meta_rd.alloc = 1'b0;
            meta_rd.refs  = '0;
            meta_rd.link  = {1'b0, rd_addr_reg} + LINK_W'(1);
        end
    end

    assign refs_inc = {1'b0, meta_rd.refs} + (REFS_W + 1)'(1);
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) || (state_reg == S_RESP && out_free);
    assign accept   = s_tvalid && s_tready;

    // Command sequencer.
    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        target_next   = target_reg;
        value_next    = value_reg;
        head_next     = head_reg;
        used_next     = used_reg;
        prev_next     = prev_reg;
        steps_next    = steps_reg;
        idx_link_next = idx_link_reg;
        res_next      = res_reg;
        meta_re       = 1'b0;
        meta_raddr    = target_reg;
        meta_we       = 1'b0;
        meta_waddr    = target_reg;
        meta_wdata    = meta_rd;
        data_we       = 1'b0;
        data_waddr    = target_reg;

        unique case (state_reg)
            S_IDLE: begin
            end

            // Decide on the slot read in the previous cycle.
            S_LOOK: begin
                state_next      = S_RESP;
                res_next.status = ST_OK;
                res_next.slot   = target_reg;
                res_next.data   = data_q;
                res_next.refs   = meta_rd.refs;
                res_next.in_use = 1'b1;
                res_next.used   = used_reg;
                case (cmd_reg) inside
                    CMD_ALLOC: begin
                        meta_we         = 1'b1;
                        meta_wdata      = '{alloc: 1'b1, refs: '0, link: meta_rd.link};
                        data_we         = 1'b1;
                        head_next       = meta_rd.link;
                        used_next       = used_reg + USED_W'(1);
                        res_next.data   = value_reg;
                        res_next.refs   = '0;
                        res_next.used   = used_reg + USED_W'(1);
                    end
                    CMD_ALLOC_AT: begin
                        if (meta_rd.alloc) begin
                            data_we       = 1'b1;
                            res_next.data = value_reg;
                        end else if (head_reg == {1'b0, target_reg}) begin
                            meta_we       = 1'b1;
                            meta_wdata    = '{alloc: 1'b1, refs: '0, link: meta_rd.link};
                            data_we       = 1'b1;
                            head_next     = meta_rd.link;
                            used_next     = used_reg + USED_W'(1);
                            res_next.data = value_reg;
                            res_next.refs = '0;
                            res_next.used = used_reg + USED_W'(1);
                        end else if (head_reg[IDX_W]) begin
                            res_next.status = ST_NOT_USED;
                            res_next.data   = '0;
                            res_next.refs   = '0;
                            res_next.in_use = 1'b0;
                        end else begin
                            // Walk the free stack from its head.
                            idx_link_next = meta_rd.link;
                            prev_next     = head_reg[IDX_W-1:0];
                            steps_next    = '0;
                            meta_re       = 1'b1;
                            meta_raddr    = head_reg[IDX_W-1:0];
                            state_next    = S_WALK;
                        end
                    end
                    CMD_SHARE, CMD_UNSHARE, CMD_READ: begin
                        if (!meta_rd.alloc) begin
                            res_next.status = ST_NOT_USED;
                            res_next.data   = '0;
                            res_next.refs   = '0;
                            res_next.in_use = 1'b0;
                        end else if (cmd_reg == CMD_SHARE) begin
                            if (refs_inc >= (REFS_W + 1)'(MAX_REFS)) begin
                                res_next.status = ST_OVERFLOW;
                            end else begin
                                meta_we         = 1'b1;
                                meta_wdata.refs = refs_inc[REFS_W-1:0];
                                res_next.refs   = refs_inc[REFS_W-1:0];
                            end
                        end else if (cmd_reg == CMD_UNSHARE) begin
                            if (meta_rd.refs > REFS_W'(1)) begin
                                meta_we         = 1'b1;
                                meta_wdata.refs = meta_rd.refs - REFS_W'(1);
                                res_next.refs   = meta_rd.refs - REFS_W'(1);
                            end else begin
                                // Last reference gone: push the slot on the free stack.
                                meta_we         = 1'b1;
                                meta_wdata      = '{alloc: 1'b0, refs: '0, link: head_reg};
                                head_next       = {1'b0, target_reg};
                                if (used_reg != '0) begin
                                    used_next = used_reg - USED_W'(1);
                                end
                                res_next.data   = '0;
                                res_next.refs   = '0;
                                res_next.in_use = 1'b0;
                                res_next.used   = (used_reg != '0) ? used_reg - USED_W'(1)
                                                                   : used_reg;
                            end
                        end
                    end
                    default: begin
                        res_next.slot   = '0;
                        res_next.data   = '0;
                        res_next.refs   = '0;
                        res_next.in_use = 1'b0;
                    end
                endcase
            end

            // One free-stack link per cycle; meta_rd holds the entry of prev_reg.
            S_WALK: begin
                if (meta_rd.link == {1'b0, target_reg}) begin
                    meta_we         = 1'b1;
                    meta_waddr      = prev_reg;
                    meta_wdata.link = idx_link_reg;
                    data_we         = 1'b1;
                    state_next      = S_CLAIM;
                end else if (steps_reg == LINK_W'(SLOTS - 1) || meta_rd.link[IDX_W]) begin
                    res_next.status = ST_NOT_USED;
                    res_next.slot   = target_reg;
                    res_next.data   = '0;
                    res_next.refs   = '0;
                    res_next.in_use = 1'b0;
                    res_next.used   = used_reg;
                    state_next      = S_RESP;
                end else begin
                    steps_next = steps_reg + LINK_W'(1);
                    prev_next  = meta_rd.link[IDX_W-1:0];
                    meta_re    = 1'b1;
                    meta_raddr = meta_rd.link[IDX_W-1:0];
                end
            end

            // Mark the unlinked slot allocated with no references.
            S_CLAIM: begin
                meta_we         = 1'b1;
                meta_wdata      = '{alloc: 1'b1, refs: '0, link: idx_link_reg};
                used_next       = used_reg + USED_W'(1);
                res_next.status = ST_OK;
                res_next.slot   = target_reg;
                res_next.data   = value_reg;
                res_next.refs   = '0;
                res_next.in_use = 1'b1;
                res_next.used   = used_reg + USED_W'(1);
                state_next      = S_RESP;
            end

            S_RESP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Take a new item: range and full checks need no memory access.
        if (accept) begin
            cmd_next        = in_cmd;
            value_next      = in_value;
            res_next.status = ST_OK;
            res_next.slot   = '0;
            res_next.data   = '0;
            res_next.refs   = '0;
            res_next.in_use = 1'b0;
            res_next.used   = used_reg;
            state_next      = S_RESP;
            if (in_cmd == CMD_ALLOC) begin
                if (head_reg[IDX_W]) begin
                    res_next.status = ST_FULL;
                end else begin
                    target_next = head_reg[IDX_W-1:0];
                    meta_re     = 1'b1;
                    meta_raddr  = head_reg[IDX_W-1:0];
                    state_next  = S_LOOK;
                end
            end else if (in_cmd > CMD_READ) begin
                res_next.status = ST_OK;
            end else if (in_index >= 8'(SLOTS)) begin
                res_next.status = ST_RANGE;
            end else begin
                target_next = in_index[IDX_W-1:0];
                meta_re     = 1'b1;
                meta_raddr  = in_index[IDX_W-1:0];
                state_next  = S_LOOK;
            end
        end
    end

    // State and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            used_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            used_reg  <= used_next;
            if (state_reg == S_RESP && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        target_reg   <= target_next;
        value_reg    <= value_next;
        prev_reg     <= prev_next;
        steps_reg    <= steps_next;
        idx_link_reg <= idx_link_next;
        res_reg      <= res_next;
        if (state_reg == S_RESP && out_free) begin
            out_reg <= res_reg;
        end
    end

    // Result item packing, status in the lowest bits.
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {
        (M_TDATA_W - RES_W)'(0),
        out_reg.used,
        out_reg.in_use,
        out_reg.refs,
        out_reg.data,
        out_reg.slot,
        out_reg.status
    };

endmodule
